// File: hdl/longest_prefix_route_lookup_defines.svh
// Assertion macros shared by the route lookup RTL.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
`define LPRL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("route lookup assertion failed");
`define LPRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route lookup sequencing assertion failed");
`else
`define LPRL_ASSERT(label, prop)
`define LPRL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/lprl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lprl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_INVAL  = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  entry_index;
    logic [31:0] entry_dest;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [2:0]  entry_port;
    logic [31:0] lookup_addr;
  } lprl_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  match_index;
    logic [31:0] next_gateway;
    logic [2:0]  out_port;
    logic        write_done;
  } lprl_out_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [2:0]  port;
  } lprl_entry_t;

  typedef struct packed {
    logic             accept;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             load_out;
  } lprl_cmd_t;

endpackage
`default_nettype wire

// File: hdl/lprl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lprl_ctrl
  import lprl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      is_lookup,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lprl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.accept    = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.rd_addr   = cnt_r;
    cmd.load_out  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = is_lookup ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // The last entry read is compared in this cycle.
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lprl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lprl_dp
  import lprl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lprl_cmd_t cmd,
  input  wire lprl_in_t  in_data,
  output lprl_out_t      out_data
);

  lprl_entry_t route_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] route_valid_r;

  logic [1:0]  mode_r;
  logic [31:0] addr_r;

  // Read stage of the scan.
  logic             rd_vld_r;
  logic             rd_hitv_r;
  logic [IDX_W-1:0] rd_idx_r;
  lprl_entry_t      rd_ent_r;

  // Best route found so far.
  logic             found_r;
  logic [31:0]      best_mask_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [31:0]      best_gw_r;
  logic [2:0]       best_port_r;

  lprl_out_t        out_data_r;

  logic             in_range;
  logic [IDX_W-1:0] waddr;
  lprl_entry_t      wr_ent;
  logic             masked_eq;
  logic             take;
  lprl_out_t        res;

  assign in_range = (32'(in_data.entry_index) < 32'(TABLE_ENTRIES));
  assign waddr    = IDX_W'(in_data.entry_index);

  always_comb begin
    wr_ent.dest    = in_data.entry_dest;
    wr_ent.mask    = in_data.entry_mask;
    wr_ent.gateway = in_data.entry_gateway;
    wr_ent.port    = in_data.entry_port;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_range && (in_data.mode == MODE_WRITE)) begin
      route_mem[waddr] <= wr_ent;
    end
    if (cmd.rd_en) begin
      rd_ent_r <= route_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_valid_r <= '0;
    end else if (cmd.accept && in_range) begin
      if (in_data.mode == MODE_WRITE) begin
        route_valid_r[waddr] <= 1'b1;
      end else if (in_data.mode == MODE_INVAL) begin
        route_valid_r[waddr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_hitv_r <= route_valid_r[cmd.rd_addr];
      rd_idx_r  <= cmd.rd_addr;
    end
    if (cmd.accept) begin
      mode_r <= in_data.mode;
      addr_r <= in_data.lookup_addr;
    end
  end

  // Entries arrive in ascending order, so >= lets a later equal mask win.
  assign masked_eq = (((addr_r ^ rd_ent_r.dest) & rd_ent_r.mask) == 32'd0);
  assign take = rd_vld_r && rd_hitv_r && masked_eq &&
                (!found_r || (rd_ent_r.mask >= best_mask_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.accept) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_mask_r <= rd_ent_r.mask;
      best_idx_r  <= rd_idx_r;
      best_gw_r   <= rd_ent_r.gateway;
      best_port_r <= rd_ent_r.port;
    end
  end

  always_comb begin
    res            = '0;
    res.write_done = (mode_r == MODE_WRITE) || (mode_r == MODE_INVAL);
    if ((mode_r == MODE_LOOKUP) && found_r) begin
      res.hit          = 1'b1;
      res.match_index  = 4'(best_idx_r);
      res.next_gateway = best_gw_r;
      res.out_port     = best_port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= res;
    end
  end

  assign out_data = out_data_r;

endmodule
`default_nettype wire

// File: hdl/longest_prefix_route_lookup.sv
// Longest-prefix route lookup over a table of TABLE_ENTRIES routes.
// Input channel (in_valid/in_ready/in_data): a write item stores a route and
// marks its slot valid, an invalidate item clears a slot, a lookup item
// gives an address. Every item produces exactly one result transfer on the
// output channel (out_valid/out_ready/out_data).
// Write and invalidate items take effect on the accepting edge; their
// acknowledgment is then loaded into the output register from the finish
// state. A lookup reads one table entry per cycle from the route memory in
// the scan state, compares the last entry in the drain state and loads the
// result in the finish state. in_ready returns together with out_valid, so
// no new item is accepted until the current one's result has been loaded.
// A new item may be accepted while the previous result still waits in the
// output register. If the receiver stalls, the next item's result is held
// in the datapath until the output register frees up, and no further item
// is accepted meanwhile.
// Reset clears every valid bit, the controller and the output valid; route
// data of slots never written are read during a scan but never selected.
`timescale 1ns / 1ps
`default_nettype none
`include "longest_prefix_route_lookup_defines.svh"
module longest_prefix_route_lookup
  import lprl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lprl_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lprl_out_t     out_data
);

  lprl_cmd_t   ctrl_cmd;
  logic        is_lookup;
  logic [38:0] miss_fields;

  assign is_lookup = (in_data.mode == MODE_LOOKUP);
  assign miss_fields = {out_data.match_index, out_data.next_gateway, out_data.out_port};

  lprl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .is_lookup (is_lookup),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (ctrl_cmd)
  );

  lprl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ctrl_cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  `LPRL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `LPRL_ASSERT(a_no_overwrite, !ctrl_cmd.load_out || !out_valid || out_ready)
  `LPRL_ASSERT(a_ack_no_hit, !(out_valid && out_data.write_done) || !out_data.hit)
  `LPRL_ASSERT(a_miss_zero, !(out_valid && !out_data.hit) || (miss_fields == 39'd0))

endmodule
`default_nettype wire
